// File: sv/bcwb_pkg.sv
package bcwb_pkg;

    localparam int TAG_W     = 32;
    localparam int LBA_W     = 44;
    localparam int SLOT_W    = 5;
    localparam int LPB_W     = 13;
    localparam int FLUSH_MAX = 32;
    localparam int CNT_W     = 6;

    localparam logic [LPB_W-1:0] LPB_RESET = 13'd8;

    typedef enum logic [1:0] {
        OP_READ  = 2'd0,
        OP_WRITE = 2'd1,
        OP_FLUSH = 2'd2,
        OP_NONE  = 2'd3
    } t_op;

    typedef enum logic [1:0] {
        ST_INVALID = 2'd0,
        ST_CLEAN   = 2'd1,
        ST_DIRTY   = 2'd2
    } t_status;

    typedef struct packed {
        t_status           status;
        logic [TAG_W-1:0]  tag;
    } t_entry;

    function automatic logic [LBA_W-1:0] lba_of(input logic [TAG_W-1:0] blk,
                                                 input logic [LPB_W-1:0] lpb);
        logic [TAG_W+LPB_W-1:0] p;
        p = {{LPB_W{1'b0}}, blk} * {{TAG_W{1'b0}}, lpb};
        return p[LBA_W-1:0];
    endfunction

endpackage

// File: sv/block_cache_write_back_policy.sv
// Write-back block cache policy, fully associative, round-robin victim.
// Command channel: drive i_op/i_block with start high; the word is taken at
// the first rising edge where start is high and busy is low. Op 3 is
// taken and dropped without a result.
// Results leave on o_valid for exactly one cycle each; the receiver cannot
// stall, so results are never held back. o_last marks the final word of a
// command.
// Config channel: i_cfg_valid/o_cfg_ready writes lbas_per_block (reset 8);
// write it only while the block is idle.
// The entry store is swept one entry per cycle through a registered read
// port. A hit returns as soon as its entry is checked; a miss sweeps every
// entry, then passes S_MISS_WB and S_MISS_FILL; a flush ends in S_FL_END
// after the sweep or after FLUSH_MAX dirty entries. Each command holds busy
// until its final word; op 3 frees the channel on the next cycle.
// Reset: a clearing pass invalidates every entry; busy stays high until it
// is done. Config writes are taken meanwhile.
module block_cache_write_back_policy #(
    parameter int CACHE_ENTRIES = 32
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        start,
    output logic                        busy,
    input  logic [1:0]                  i_op,
    input  logic [31:0]                 i_block,
    input  logic                        i_cfg_valid,
    output logic                        o_cfg_ready,
    input  logic [12:0]                 i_cfg_data,
    output logic                        o_valid,
    output logic [4:0]                  o_slot,
    output logic                        o_hit,
    output logic                        o_writeback,
    output logic [43:0]                 o_writeback_lba,
    output logic                        o_fill,
    output logic [43:0]                 o_fill_lba,
    output logic                        o_last
);
    import bcwb_pkg::*;

    localparam int IW = $clog2(CACHE_ENTRIES);
    localparam logic [IW-1:0] LAST_IDX = IW'(CACHE_ENTRIES - 1);

    typedef enum logic [2:0] {
        S_CLR, S_IDLE, S_SCAN, S_MISS_WB, S_MISS_FILL, S_FL_END
    } t_state;

    t_state             r_state;
    logic [IW-1:0]      r_idx;
    logic               r_issue;
    logic               r_chk_vld;
    logic [IW-1:0]      r_chk_idx;
    t_op                r_op;
    logic [TAG_W-1:0]   r_blk;
    logic               r_free_vld;
    logic [IW-1:0]      r_free_idx;
    logic [TAG_W-1:0]   r_vic_tag;
    logic               r_vic_dirty;
    logic [IW-1:0]      r_vic_ptr;
    logic [IW-1:0]      r_targ;
    logic               r_wb;
    logic [LBA_W-1:0]   r_wb_lba;
    logic [CNT_W-1:0]   r_cnt;
    logic               r_pend_vld;
    logic [IW-1:0]      r_pend_slot;
    logic [LBA_W-1:0]   r_pend_lba;
    logic [LPB_W-1:0]   r_lbas;

    logic               r_out_vld;
    logic [SLOT_W-1:0]  r_out_slot;
    logic               r_out_hit;
    logic               r_out_wb;
    logic [LBA_W-1:0]   r_out_wb_lba;
    logic               r_out_fill;
    logic [LBA_W-1:0]   r_out_fill_lba;
    logic               r_out_last;

    logic               mem_we;
    logic [IW-1:0]      mem_waddr;
    t_entry             mem_wdata;
    t_entry             rd;
    logic [TAG_W-1:0]   mul_blk;
    logic [LBA_W-1:0]   prod;
    logic               rd_hit;
    logic               rd_dirty;
    logic               chk_last;

    bcwb_mem #(.DEPTH(CACHE_ENTRIES), .AW(IW)) u_mem (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (mem_waddr),
        .i_wdata (mem_wdata),
        .i_raddr (r_idx),
        .o_rdata (rd)
    );

    assign rd_hit   = (rd.status != ST_INVALID) && (rd.tag == r_blk);
    assign rd_dirty = (rd.status == ST_DIRTY);
    assign chk_last = (r_chk_idx == LAST_IDX);

    // one shared multiplier, operand picked by state
    always_comb begin
        case (r_state)
            S_SCAN:    mul_blk = rd.tag;
            S_MISS_WB: mul_blk = r_vic_tag;
            default:   mul_blk = r_blk;
        endcase
        prod = lba_of(mul_blk, r_lbas);
    end

    always_comb begin
        mem_we    = 1'b0;
        mem_waddr = r_chk_idx;
        mem_wdata = '{status: ST_CLEAN, tag: rd.tag};
        case (r_state)
            S_CLR: begin
                mem_we    = 1'b1;
                mem_waddr = r_idx;
                mem_wdata = '{status: ST_INVALID, tag: '0};
            end
            S_SCAN: begin
                if (r_chk_vld) begin
                    if (r_op == OP_FLUSH) begin
                        mem_we = rd_dirty;
                    end else if (rd_hit && r_op == OP_WRITE) begin
                        mem_we    = 1'b1;
                        mem_wdata = '{status: ST_DIRTY, tag: rd.tag};
                    end
                end
            end
            S_MISS_FILL: begin
                mem_we    = 1'b1;
                mem_waddr = r_targ;
                mem_wdata = '{status: (r_op == OP_WRITE) ? ST_DIRTY : ST_CLEAN, tag: r_blk};
            end
            default: begin
                mem_we = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_CLR;
            r_idx      <= '0;
            r_issue    <= 1'b0;
            r_chk_vld  <= 1'b0;
            r_vic_ptr  <= '0;
            r_pend_vld <= 1'b0;
            r_free_vld <= 1'b0;
            r_cnt      <= '0;
            r_out_vld  <= 1'b0;
            r_lbas     <= LPB_RESET;
        end else begin
            r_out_vld <= 1'b0;
            if (i_cfg_valid) begin
                r_lbas <= i_cfg_data;
            end
            case (r_state)
                S_CLR: begin
                    if (r_idx == LAST_IDX) begin
                        r_idx   <= '0;
                        r_state <= S_IDLE;
                    end else begin
                        r_idx <= r_idx + 1'b1;
                    end
                end
                S_IDLE: begin
                    if (start) begin
                        r_op  <= t_op'(i_op);
                        r_blk <= i_block;
                        if (i_op != OP_NONE) begin
                            r_idx      <= '0;
                            r_issue    <= 1'b1;
                            r_chk_vld  <= 1'b0;
                            r_free_vld <= 1'b0;
                            r_cnt      <= '0;
                            r_pend_vld <= 1'b0;
                            r_state    <= S_SCAN;
                        end
                    end
                end
                S_SCAN: begin
                    if (r_issue) begin
                        if (r_idx == LAST_IDX) begin
                            r_issue <= 1'b0;
                        end else begin
                            r_idx <= r_idx + 1'b1;
                        end
                    end
                    r_chk_vld <= r_issue;
                    r_chk_idx <= r_idx;
                    if (r_chk_vld) begin
                        if (r_op == OP_FLUSH) begin
                            if (rd_dirty) begin
                                r_pend_vld  <= 1'b1;
                                r_pend_slot <= r_chk_idx;
                                r_pend_lba  <= prod;
                                r_cnt       <= r_cnt + 1'b1;
                                if (r_pend_vld) begin
                                    r_out_vld      <= 1'b1;
                                    r_out_slot     <= SLOT_W'(r_pend_slot);
                                    r_out_hit      <= 1'b0;
                                    r_out_wb       <= 1'b1;
                                    r_out_wb_lba   <= r_pend_lba;
                                    r_out_fill     <= 1'b0;
                                    r_out_fill_lba <= '0;
                                    r_out_last     <= 1'b0;
                                end
                            end
                            if (chk_last || (rd_dirty && r_cnt == CNT_W'(FLUSH_MAX - 1))) begin
                                r_issue   <= 1'b0;
                                r_chk_vld <= 1'b0;
                                r_state   <= S_FL_END;
                            end
                        end else if (rd_hit) begin
                            r_out_vld      <= 1'b1;
                            r_out_slot     <= SLOT_W'(r_chk_idx);
                            r_out_hit      <= 1'b1;
                            r_out_wb       <= 1'b0;
                            r_out_wb_lba   <= '0;
                            r_out_fill     <= 1'b0;
                            r_out_fill_lba <= '0;
                            r_out_last     <= 1'b1;
                            r_issue        <= 1'b0;
                            r_chk_vld      <= 1'b0;
                            r_state        <= S_IDLE;
                        end else begin
                            if (rd.status == ST_INVALID && !r_free_vld) begin
                                r_free_vld <= 1'b1;
                                r_free_idx <= r_chk_idx;
                            end
                            if (r_chk_idx == r_vic_ptr) begin
                                r_vic_tag   <= rd.tag;
                                r_vic_dirty <= rd_dirty;
                            end
                            if (chk_last) begin
                                r_issue   <= 1'b0;
                                r_chk_vld <= 1'b0;
                                r_state   <= S_MISS_WB;
                            end
                        end
                    end
                end
                S_MISS_WB: begin
                    if (r_free_vld) begin
                        r_targ   <= r_free_idx;
                        r_wb     <= 1'b0;
                        r_wb_lba <= '0;
                    end else begin
                        r_targ    <= r_vic_ptr;
                        r_wb      <= r_vic_dirty;
                        r_wb_lba  <= r_vic_dirty ? prod : '0;
                        r_vic_ptr <= (r_vic_ptr == LAST_IDX) ? '0 : r_vic_ptr + 1'b1;
                    end
                    r_state <= S_MISS_FILL;
                end
                S_MISS_FILL: begin
                    r_out_vld      <= 1'b1;
                    r_out_slot     <= SLOT_W'(r_targ);
                    r_out_hit      <= 1'b0;
                    r_out_wb       <= r_wb;
                    r_out_wb_lba   <= r_wb_lba;
                    r_out_fill     <= 1'b1;
                    r_out_fill_lba <= prod;
                    r_out_last     <= 1'b1;
                    r_state        <= S_IDLE;
                end
                S_FL_END: begin
                    r_out_vld      <= 1'b1;
                    r_out_slot     <= r_pend_vld ? SLOT_W'(r_pend_slot) : '0;
                    r_out_hit      <= 1'b0;
                    r_out_wb       <= r_pend_vld;
                    r_out_wb_lba   <= r_pend_vld ? r_pend_lba : '0;
                    r_out_fill     <= 1'b0;
                    r_out_fill_lba <= '0;
                    r_out_last     <= 1'b1;
                    r_pend_vld     <= 1'b0;
                    r_state        <= S_IDLE;
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign busy            = (r_state != S_IDLE);
    assign o_cfg_ready     = 1'b1;
    assign o_valid         = r_out_vld;
    assign o_slot          = r_out_slot;
    assign o_hit           = r_out_hit;
    assign o_writeback     = r_out_wb;
    assign o_writeback_lba = r_out_wb_lba;
    assign o_fill          = r_out_fill;
    assign o_fill_lba      = r_out_fill_lba;
    assign o_last          = r_out_last;

endmodule

// File: sv/bcwb_mem.sv
module bcwb_mem #(
    parameter int DEPTH = 32,
    parameter int AW    = 5
) (
    input  logic               i_clk,
    input  logic               i_we,
    input  logic [AW-1:0]      i_waddr,
    input  bcwb_pkg::t_entry   i_wdata,
    input  logic [AW-1:0]      i_raddr,
    output bcwb_pkg::t_entry   o_rdata
);
    import bcwb_pkg::*;

    t_entry r_mem [DEPTH];
    t_entry r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// File: sv/bcwb_chk.sv
module bcwb_chk (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         start,
    input  logic         busy,
    input  logic         o_valid,
    input  logic         o_hit,
    input  logic         o_writeback,
    input  logic [43:0]  o_writeback_lba,
    input  logic         o_fill,
    input  logic         o_last
);

    // nothing comes out in the cycle right after a command is taken
    a_no_early_word: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> !o_valid)
        else $error("result word right after command accept");

    // more flush words pending keeps the block busy
    a_more_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !o_last) |-> busy)
        else $error("non-final word while idle");

    // final word frees the command channel
    a_last_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_last) |-> !busy)
        else $error("busy after final word");

    // hit words carry no device traffic
    a_hit_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_hit) |-> (!o_fill && !o_writeback && o_last))
        else $error("hit word with device command");

    // lba zero when no writeback
    a_wb_lba: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !o_writeback) |-> (o_writeback_lba == '0))
        else $error("stray writeback lba");

endmodule

bind block_cache_write_back_policy bcwb_chk u_bcwb_chk (.*);
